/* rtl/core/rafm_pkg.sv */
// Shared widths, angle constants and the arctangent table for the rotation angle block.
`default_nettype none

package rafm_pkg;

  localparam int IN_W       = 16;
  localparam int OUT_W      = 16;
  localparam int ANGLE_BITS = 30;
  localparam int SQ_W       = 32;
  localparam int SUM_W      = 34;
  localparam int RAD_W      = 64;
  localparam int ROOT_W     = 32;
  localparam int REM_W      = 34;
  localparam int ZW         = 34;
  localparam int ATAN_N     = 32;

  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

  localparam logic [31:0] ATAN_Q30 [ATAN_N] = '{
    32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158,
    32'd67021686,  32'd33543515,  32'd16775850,  32'd8388437,
    32'd4194282,   32'd2097149,   32'd1048575,   32'd524287,
    32'd262143,    32'd131071,    32'd65535,     32'd32767,
    32'd16383,     32'd8191,      32'd4095,      32'd2047,
    32'd1023,      32'd511,       32'd255,       32'd127,
    32'd63,        32'd31,        32'd15,        32'd7,
    32'd3,         32'd1,         32'd0,         32'd0
  };

  typedef struct packed {
    logic signed [IN_W-1:0] e00;
    logic signed [IN_W-1:0] e01;
    logic signed [IN_W-1:0] e02;
    logic signed [IN_W-1:0] e10;
    logic signed [IN_W-1:0] e11;
    logic signed [IN_W-1:0] e12;
    logic signed [IN_W-1:0] e20;
    logic signed [IN_W-1:0] e21;
    logic signed [IN_W-1:0] e22;
  } matrix_t;

endpackage

`default_nettype wire

/* rtl/core/rafm_ifs.sv */
// Valid/ready channel interfaces for the matrix input and the angle result.
`default_nettype none

interface rafm_in_if;
  logic                          valid;
  logic                          ready;
  logic signed [rafm_pkg::IN_W-1:0] entry_00;
  logic signed [rafm_pkg::IN_W-1:0] entry_01;
  logic signed [rafm_pkg::IN_W-1:0] entry_02;
  logic signed [rafm_pkg::IN_W-1:0] entry_10;
  logic signed [rafm_pkg::IN_W-1:0] entry_11;
  logic signed [rafm_pkg::IN_W-1:0] entry_12;
  logic signed [rafm_pkg::IN_W-1:0] entry_20;
  logic signed [rafm_pkg::IN_W-1:0] entry_21;
  logic signed [rafm_pkg::IN_W-1:0] entry_22;

  modport source (
    output valid, entry_00, entry_01, entry_02, entry_10, entry_11, entry_12,
           entry_20, entry_21, entry_22,
    input  ready
  );
  modport sink (
    input  valid, entry_00, entry_01, entry_02, entry_10, entry_11, entry_12,
           entry_20, entry_21, entry_22,
    output ready
  );
endinterface

interface rafm_out_if;
  logic                          valid;
  logic                          ready;
  logic [rafm_pkg::OUT_W-1:0]    rotation_angle;

  modport source (output valid, rotation_angle, input ready);
  modport sink (input valid, rotation_angle, output ready);
endinterface

`default_nettype wire

/* rtl/core/rafm_front.sv */
// Front stages: trace minus one, axis components squared, then their sum as a root radicand.
`default_nettype none

module rafm_front #(
  parameter int FRAC_BITS = 14,
  parameter int C_W       = 19
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            en,
  input  wire logic                            v_in,
  input  wire rafm_pkg::matrix_t               mat_in,
  output logic                                 v_out,
  output logic signed [C_W-1:0]                c_out,
  output logic [rafm_pkg::RAD_W-1:0]           rad_out
);

  localparam logic signed [C_W-1:0] ONE = C_W'(64'd1 << FRAC_BITS);

  logic signed [rafm_pkg::IN_W-1:0] e00, e11, e22;
  logic signed [rafm_pkg::IN_W:0]   a0, a1, a2;
  logic signed [2*rafm_pkg::IN_W+1:0] p0, p1, p2;
  logic signed [C_W-1:0]            c_nxt;
  logic [rafm_pkg::SQ_W-1:0]        sq0_r, sq1_r, sq2_r;
  logic signed [C_W-1:0]            c1_r, c2_r;
  logic                             v1_r, v2_r;
  logic [rafm_pkg::SUM_W-1:0]       sum_nxt, sum_r;

  assign e00 = mat_in.e00;
  assign e11 = mat_in.e11;
  assign e22 = mat_in.e22;

  always_comb begin
    a0    = {mat_in.e21[rafm_pkg::IN_W-1], mat_in.e21} - {mat_in.e12[rafm_pkg::IN_W-1], mat_in.e12};
    a1    = {mat_in.e02[rafm_pkg::IN_W-1], mat_in.e02} - {mat_in.e20[rafm_pkg::IN_W-1], mat_in.e20};
    a2    = {mat_in.e10[rafm_pkg::IN_W-1], mat_in.e10} - {mat_in.e01[rafm_pkg::IN_W-1], mat_in.e01};
    p0    = a0 * a0;
    p1    = a1 * a1;
    p2    = a2 * a2;
    c_nxt = C_W'(e00) + C_W'(e11) + C_W'(e22) - ONE;
    sum_nxt = rafm_pkg::SUM_W'(sq0_r) + rafm_pkg::SUM_W'(sq1_r) + rafm_pkg::SUM_W'(sq2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= v_in;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq0_r <= p0[rafm_pkg::SQ_W-1:0];
      sq1_r <= p1[rafm_pkg::SQ_W-1:0];
      sq2_r <= p2[rafm_pkg::SQ_W-1:0];
      c1_r  <= c_nxt;
      sum_r <= sum_nxt;
      c2_r  <= c1_r;
    end
  end

  assign v_out   = v2_r;
  assign c_out   = c2_r;
  assign rad_out = {sum_r, {(rafm_pkg::RAD_W-rafm_pkg::SUM_W){1'b0}}};

endmodule

`default_nettype wire

/* rtl/core/rafm_sqrt_cell.sv */
// One cell of the square root chain: settles one root bit from two radicand bits.
`default_nettype none

module rafm_sqrt_cell #(
  parameter int C_W = 19
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          v_in,
  input  wire logic signed [C_W-1:0]         c_in,
  input  wire logic [rafm_pkg::RAD_W-1:0]    rad_in,
  input  wire logic [rafm_pkg::REM_W-1:0]    rem_in,
  input  wire logic [rafm_pkg::ROOT_W-1:0]   q_in,
  output logic                               v_out,
  output logic signed [C_W-1:0]              c_out,
  output logic [rafm_pkg::RAD_W-1:0]         rad_out,
  output logic [rafm_pkg::REM_W-1:0]         rem_out,
  output logic [rafm_pkg::ROOT_W-1:0]        q_out
);

  logic [rafm_pkg::REM_W+1:0]  rem_sh, trial;
  logic [rafm_pkg::REM_W-1:0]  rem_nxt, rem_r;
  logic [rafm_pkg::ROOT_W-1:0] q_nxt, q_r;
  logic [rafm_pkg::RAD_W-1:0]  rad_r;
  logic signed [C_W-1:0]       c_r;
  logic                        v_r;

  always_comb begin
    rem_sh = {rem_in, rad_in[rafm_pkg::RAD_W-1 -: 2]};
    trial  = {2'b00, q_in, 2'b01};
    if (rem_sh >= trial) begin
      rem_nxt = rafm_pkg::REM_W'(rem_sh - trial);
      q_nxt   = {q_in[rafm_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      rem_nxt = rafm_pkg::REM_W'(rem_sh);
      q_nxt   = {q_in[rafm_pkg::ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r   <= c_in;
      rad_r <= {rad_in[rafm_pkg::RAD_W-3:0], 2'b00};
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign v_out   = v_r;
  assign c_out   = c_r;
  assign rad_out = rad_r;
  assign rem_out = rem_r;
  assign q_out   = q_r;

endmodule

`default_nettype wire

/* rtl/core/rafm_cordic_cell.sv */
// One vectoring micro-rotation of the arctangent chain.
`default_nettype none

module rafm_cordic_cell #(
  parameter int XW   = 37,
  parameter int STEP = 0
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            en,
  input  wire logic                            v_in,
  input  wire logic                            hold_in,
  input  wire logic signed [XW-1:0]            x_in,
  input  wire logic signed [XW-1:0]            y_in,
  input  wire logic signed [rafm_pkg::ZW-1:0]  z_in,
  output logic                                 v_out,
  output logic                                 hold_out,
  output logic signed [XW-1:0]                 x_out,
  output logic signed [XW-1:0]                 y_out,
  output logic signed [rafm_pkg::ZW-1:0]       z_out
);

  localparam int SH = STEP % rafm_pkg::ATAN_N;
  localparam logic signed [rafm_pkg::ZW-1:0] ANG =
    {{(rafm_pkg::ZW-32){1'b0}}, rafm_pkg::ATAN_Q30[SH]};

  logic signed [XW-1:0]           dx, dy;
  logic signed [XW-1:0]           x_nxt, y_nxt, x_r, y_r;
  logic signed [rafm_pkg::ZW-1:0] z_nxt, z_r;
  logic                           v_r, hold_r;

  always_comb begin
    dy    = y_in >>> SH;
    dx    = x_in >>> SH;
    x_nxt = x_in;
    y_nxt = y_in;
    z_nxt = z_in;
    if (!hold_in) begin
      if (y_in > 0) begin
        x_nxt = x_in + dy;
        y_nxt = y_in - dx;
        z_nxt = z_in + ANG;
      end else begin
        x_nxt = x_in - dy;
        y_nxt = y_in + dx;
        z_nxt = z_in - ANG;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hold_r <= hold_in;
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
    end
  end

  assign v_out    = v_r;
  assign hold_out = hold_r;
  assign x_out    = x_r;
  assign y_out    = y_r;
  assign z_out    = z_r;

endmodule

`default_nettype wire

/* rtl/core/rafm_back.sv */
// Angle clamp and rounding, output register and skid register of the result channel.
`default_nettype none

module rafm_back #(
  parameter int FRAC_BITS = 14
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            v_in,
  input  wire logic signed [rafm_pkg::ZW-1:0]  z_in,
  input  wire logic                            out_ready,
  output logic                                 out_valid,
  output logic [rafm_pkg::OUT_W-1:0]           out_angle,
  output logic                                 advance
);

  localparam int SH = rafm_pkg::ANGLE_BITS - FRAC_BITS;
  localparam logic [63:0] HALF = (64'd1 << SH) >> 1;
  localparam logic signed [rafm_pkg::ZW-1:0] PI_Z = {{(rafm_pkg::ZW-32){1'b0}}, rafm_pkg::PI_Q30};

  logic [31:0]                zc;
  logic [63:0]                z_sum;
  logic [rafm_pkg::OUT_W-1:0] angle_nxt;
  logic [rafm_pkg::OUT_W-1:0] out_data_r, skid_data_r;
  logic                       out_v_r, skid_v_r;

  always_comb begin
    if (z_in < 0) begin
      zc = 32'd0;
    end else if (z_in > PI_Z) begin
      zc = rafm_pkg::PI_Q30;
    end else begin
      zc = z_in[31:0];
    end
    z_sum     = {32'd0, zc} + HALF;
    angle_nxt = rafm_pkg::OUT_W'(z_sum >> SH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_ready) begin
        out_data_r <= skid_data_r;
        skid_v_r   <= 1'b0;
      end
    end else if (v_in) begin
      if (!out_v_r || out_ready) begin
        out_v_r    <= 1'b1;
        out_data_r <= angle_nxt;
      end else begin
        skid_v_r    <= 1'b1;
        skid_data_r <= angle_nxt;
      end
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  assign out_valid = out_v_r;
  assign out_angle = out_data_r;
  assign advance   = !skid_v_r;

endmodule

`default_nettype wire

/* rtl/core/rotation_angle_from_matrix_top.sv */
// Top level of the rotation angle unit: root chain, arctangent chain and result buffering.
`default_nettype none

// Takes a 3x3 rotation matrix in signed fixed point with FRAC_BITS fractional bits and
// returns its rotation angle atan2(|axis|, trace - 1) in radians, 0 to pi, with FRAC_BITS
// fractional bits, rounded to nearest. One matrix is taken every cycle while the chain is
// not halted; an input passes through two front stages, a chain of 32 square root cells,
// one setup stage, CORDIC_STEPS arctangent cells and the output register. The whole chain
// moves together and only halts while both the output register and the skid register
// behind it hold a result that has not been taken, so the input stays ready while one
// finished result waits. There is no state between items and no start-up delay after
// reset.
module rotation_angle_from_matrix_top #(
  parameter int FRAC_BITS    = 14,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  rafm_in_if.sink     in_ch,
  rafm_out_if.source  out_ch
);

  localparam int C_W    = (FRAC_BITS > 16) ? FRAC_BITS + 2 : 19;
  localparam int XS_W   = C_W + 15;
  localparam int XW     = C_W + 18;
  localparam int ROOT_W = rafm_pkg::ROOT_W;

  logic en;
  rafm_pkg::matrix_t mat;

  logic                            sq_v   [ROOT_W+1];
  logic signed [C_W-1:0]           sq_c   [ROOT_W+1];
  logic [rafm_pkg::RAD_W-1:0]      sq_rad [ROOT_W+1];
  logic [rafm_pkg::REM_W-1:0]      sq_rem [ROOT_W+1];
  logic [ROOT_W-1:0]               sq_q   [ROOT_W+1];

  logic                            cd_v    [CORDIC_STEPS+1];
  logic                            cd_hold [CORDIC_STEPS+1];
  logic signed [XW-1:0]            cd_x    [CORDIC_STEPS+1];
  logic signed [XW-1:0]            cd_y    [CORDIC_STEPS+1];
  logic signed [rafm_pkg::ZW-1:0]  cd_z    [CORDIC_STEPS+1];

  logic signed [C_W-1:0]           c_fin;
  logic [rafm_pkg::REM_W-1:0]      rem_fin;
  logic [ROOT_W-1:0]               q_fin;
  logic [ROOT_W:0]                 y_rnd;
  logic signed [XS_W-1:0]          x_sh;
  logic signed [XW-1:0]            x_ext, y_ext;
  logic signed [XW-1:0]            x0_nxt, y0_nxt, x0_r, y0_r;
  logic signed [rafm_pkg::ZW-1:0]  z0_nxt, z0_r;
  logic                            hold0_nxt, hold0_r, v0_r;

  assign mat.e00 = in_ch.entry_00;
  assign mat.e01 = in_ch.entry_01;
  assign mat.e02 = in_ch.entry_02;
  assign mat.e10 = in_ch.entry_10;
  assign mat.e11 = in_ch.entry_11;
  assign mat.e12 = in_ch.entry_12;
  assign mat.e20 = in_ch.entry_20;
  assign mat.e21 = in_ch.entry_21;
  assign mat.e22 = in_ch.entry_22;

  assign in_ch.ready = en;

  rafm_front #(
    .FRAC_BITS (FRAC_BITS),
    .C_W       (C_W)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .v_in    (in_ch.valid),
    .mat_in  (mat),
    .v_out   (sq_v[0]),
    .c_out   (sq_c[0]),
    .rad_out (sq_rad[0])
  );

  assign sq_rem[0] = '0;
  assign sq_q[0]   = '0;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    rafm_sqrt_cell #(
      .C_W (C_W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .v_in    (sq_v[k]),
      .c_in    (sq_c[k]),
      .rad_in  (sq_rad[k]),
      .rem_in  (sq_rem[k]),
      .q_in    (sq_q[k]),
      .v_out   (sq_v[k+1]),
      .c_out   (sq_c[k+1]),
      .rad_out (sq_rad[k+1]),
      .rem_out (sq_rem[k+1]),
      .q_out   (sq_q[k+1])
    );
  end

  assign c_fin   = sq_c[ROOT_W];
  assign rem_fin = sq_rem[ROOT_W];
  assign q_fin   = sq_q[ROOT_W];

  // A root of zero can only come from a zero radicand, so the angle is then fixed at once.
  always_comb begin
    y_rnd     = {1'b0, q_fin} + (ROOT_W+1)'(rem_fin > {2'b00, q_fin});
    x_sh      = {c_fin, 15'd0};
    x_ext     = {{(XW-XS_W){x_sh[XS_W-1]}}, x_sh};
    y_ext     = {{(XW-ROOT_W-1){1'b0}}, y_rnd};
    hold0_nxt = (q_fin == '0);
    x0_nxt    = x_ext;
    y0_nxt    = y_ext;
    z0_nxt    = '0;
    if (hold0_nxt) begin
      if (c_fin < 0) begin
        z0_nxt = {{(rafm_pkg::ZW-32){1'b0}}, rafm_pkg::PI_Q30};
      end
    end else if (c_fin < 0) begin
      x0_nxt = y_ext;
      y0_nxt = -x_ext;
      z0_nxt = {{(rafm_pkg::ZW-32){1'b0}}, rafm_pkg::HALF_PI_Q30};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= sq_v[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hold0_r <= hold0_nxt;
      x0_r    <= x0_nxt;
      y0_r    <= y0_nxt;
      z0_r    <= z0_nxt;
    end
  end

  assign cd_v[0]    = v0_r;
  assign cd_hold[0] = hold0_r;
  assign cd_x[0]    = x0_r;
  assign cd_y[0]    = y0_r;
  assign cd_z[0]    = z0_r;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    rafm_cordic_cell #(
      .XW   (XW),
      .STEP (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .v_in     (cd_v[i]),
      .hold_in  (cd_hold[i]),
      .x_in     (cd_x[i]),
      .y_in     (cd_y[i]),
      .z_in     (cd_z[i]),
      .v_out    (cd_v[i+1]),
      .hold_out (cd_hold[i+1]),
      .x_out    (cd_x[i+1]),
      .y_out    (cd_y[i+1]),
      .z_out    (cd_z[i+1])
    );
  end

  rafm_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .v_in      (cd_v[CORDIC_STEPS]),
    .z_in      (cd_z[CORDIC_STEPS]),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_angle (out_ch.rotation_angle),
    .advance   (en)
  );

endmodule

`default_nettype wire

/* rtl/core/rafm_checker.sv */
// Port-level checks of the rotation angle unit and their binding to the top level.
`default_nettype none

module rafm_checker #(
  parameter int FRAC_BITS = 14
) (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [rafm_pkg::OUT_W-1:0] out_angle
);

  localparam int SH = rafm_pkg::ANGLE_BITS - FRAC_BITS;
  localparam logic [63:0] MAX_ANGLE = ({32'd0, rafm_pkg::PI_Q30} + ((64'd1 << SH) >> 1)) >> SH;
  localparam bit ANGLE_FITS = (MAX_ANGLE < 64'd65536);

  a_out_valid_held : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before its transfer");

  a_out_data_held : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_angle))
    else $error("stalled result changed");

  a_stall_needs_result : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result on offer");

  a_stall_persists : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready && !out_ready |=> !in_ready)
    else $error("input released while both result registers stayed full");

  a_angle_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ANGLE_FITS && in_valid |-> out_angle <= MAX_ANGLE[rafm_pkg::OUT_W-1:0])
    else $error("angle above pi");

endmodule

bind rotation_angle_from_matrix_top rafm_checker #(
  .FRAC_BITS (FRAC_BITS)
) u_rafm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_angle (out_ch.rotation_angle)
);

`default_nettype wire

/* bench/tb_rotation_angle_from_matrix_top.sv */
// Testbench for the rotation angle unit: streamed matrices checked against an angle predictor.
`timescale 1ns / 1ps

module tb_rotation_angle_from_matrix_top;

  localparam int  FRAC_BITS    = 14;
  localparam int  CORDIC_STEPS = 16;
  localparam int  ROUND_SHIFT  = rafm_pkg::ANGLE_BITS - FRAC_BITS;
  localparam int  DRAIN_CYCLES = CORDIC_STEPS + 60;
  localparam int  CYCLE_LIMIT  = 400000;
  localparam real PI_REAL      = 3.14159265358979;

  logic clk;
  logic rst_n;

  rafm_in_if  in_if ();
  rafm_out_if out_if ();

  rotation_angle_from_matrix_top #(
    .FRAC_BITS    (FRAC_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  rafm_pkg::matrix_t pending_matrices [$];
  logic [15:0]       angle_expected [$];
  rafm_pkg::matrix_t held_matrix;
  logic [15:0]       angle_want;
  int          items_queued = 0;
  int          items_taken = 0;
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          idle_by_phase [4] = '{0, 68, 0, 12};
  int          stall_by_phase [4] = '{0, 0, 68, 12};
  int          items_by_phase [4] = '{190, 190, 190, 180};

  always #5 clk = ~clk;

  function automatic logic [15:0] rotation_angle_of(rafm_pkg::matrix_t m);
    longint          trace_m1, ax0, ax1, ax2, x, y, z, x_old;
    longint unsigned sum_sq, radicand, rem, root, bit_w;
    int              i;
    trace_m1 = longint'($signed(m.e00)) + longint'($signed(m.e11))
             + longint'($signed(m.e22)) - (longint'(1) << FRAC_BITS);
    ax0 = longint'($signed(m.e21)) - longint'($signed(m.e12));
    ax1 = longint'($signed(m.e02)) - longint'($signed(m.e20));
    ax2 = longint'($signed(m.e10)) - longint'($signed(m.e01));
    sum_sq = longint'(ax0 * ax0 + ax1 * ax1 + ax2 * ax2);
    radicand = sum_sq << 30;
    rem = radicand;
    root = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > rem) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (rem >= root + bit_w) begin
        rem = rem - (root + bit_w);
        root = (root >> 1) + bit_w;
      end else begin
        root = root >> 1;
      end
      bit_w = bit_w >> 2;
    end
    if (radicand - root * root > root) root = root + 1;
    y = longint'(root);
    if (y == 0) begin
      z = (trace_m1 >= 0) ? 0 : longint'({32'd0, rafm_pkg::PI_Q30});
    end else begin
      x = trace_m1 * 32768;
      z = 0;
      if (x < 0) begin
        x_old = x;
        x = y;
        y = -x_old;
        z = longint'({32'd0, rafm_pkg::HALF_PI_Q30});
      end
      for (i = 0; i < CORDIC_STEPS; i++) begin
        x_old = x;
        if (y > 0) begin
          x = x + (y >>> (i & 31));
          y = y - (x_old >>> (i & 31));
          z = z + longint'({32'd0, rafm_pkg::ATAN_Q30[i & 31]});
        end else begin
          x = x - (y >>> (i & 31));
          y = y + (x_old >>> (i & 31));
          z = z - longint'({32'd0, rafm_pkg::ATAN_Q30[i & 31]});
        end
      end
    end
    if (z < 0) z = 0;
    if (z > longint'({32'd0, rafm_pkg::PI_Q30})) z = longint'({32'd0, rafm_pkg::PI_Q30});
    if (ROUND_SHIFT > 0) z = (z + (longint'(1) << (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
    return z[15:0];
  endfunction

  function automatic logic [15:0] to_fixed(real v, int jitter_amp);
    real scaled;
    int  q;
    scaled = v * real'(1 << FRAC_BITS);
    q = $rtoi(scaled >= 0.0 ? scaled + 0.5 : scaled - 0.5);
    if (jitter_amp > 0) q = q + int'($urandom_range(0, 2 * jitter_amp)) - jitter_amp;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  // Mostly true rotations about a random axis, with the angle often pushed towards
  // nought or pi; the rest are raw bit patterns and mixtures of extreme entries.
  function automatic rafm_pkg::matrix_t random_matrix();
    real         kx, ky, kz, norm, theta, co, si, vc;
    real         r [9];
    logic [15:0] e [9];
    int          kind, jit, j;
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      kx = $urandom_range(0, 2000000) / 1000000.0 - 1.0;
      ky = $urandom_range(0, 2000000) / 1000000.0 - 1.0;
      kz = $urandom_range(0, 2000000) / 1000000.0 - 1.0;
      norm = $sqrt(kx * kx + ky * ky + kz * kz);
      if (norm < 0.05) begin
        kx = 0.0;
        ky = 0.0;
        kz = 1.0;
        norm = 1.0;
      end
      kx = kx / norm;
      ky = ky / norm;
      kz = kz / norm;
      case ($urandom_range(0, 5))
        0:       theta = $urandom_range(0, 1000) * 1.0e-5;
        1:       theta = PI_REAL - $urandom_range(0, 1000) * 1.0e-5;
        default: theta = PI_REAL * ($urandom_range(0, 1000000) / 1000000.0);
      endcase
      co = $cos(theta);
      si = $sin(theta);
      vc = 1.0 - co;
      r[0] = co + vc * kx * kx;
      r[1] = vc * kx * ky - si * kz;
      r[2] = vc * kx * kz + si * ky;
      r[3] = vc * kx * ky + si * kz;
      r[4] = co + vc * ky * ky;
      r[5] = vc * ky * kz - si * kx;
      r[6] = vc * kx * kz - si * ky;
      r[7] = vc * ky * kz + si * kx;
      r[8] = co + vc * kz * kz;
      jit = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 4)) : 0;
      for (j = 0; j < 9; j++) e[j] = to_fixed(r[j], jit);
    end else if (kind < 80) begin
      for (j = 0; j < 9; j++) e[j] = 16'($urandom());
    end else begin
      for (j = 0; j < 9; j++) begin
        case ($urandom_range(0, 5))
          0:       e[j] = 16'h8000;
          1:       e[j] = 16'h7fff;
          2:       e[j] = 16'h0000;
          3:       e[j] = 16'h4000;
          4:       e[j] = 16'hc000;
          default: e[j] = 16'($urandom());
        endcase
      end
    end
    return {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
  endfunction

  task automatic queue_matrix(rafm_pkg::matrix_t m);
    pending_matrices.insert(pending_matrices.size(), m);
    items_queued++;
  endtask

  task automatic queue_entries(int a00, int a01, int a02, int a10, int a11, int a12,
                               int a20, int a21, int a22);
    rafm_pkg::matrix_t m;
    m.e00 = 16'(a00);
    m.e01 = 16'(a01);
    m.e02 = 16'(a02);
    m.e10 = 16'(a10);
    m.e11 = 16'(a11);
    m.e12 = 16'(a12);
    m.e20 = 16'(a20);
    m.e21 = 16'(a21);
    m.e22 = 16'(a22);
    queue_matrix(m);
  endtask

  task automatic report_mismatch(string what, logic [15:0] want, logic [15:0] got);
    $display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        angle_expected.insert(angle_expected.size(), rotation_angle_of(held_matrix));
        items_taken++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_matrices.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          held_matrix = pending_matrices[0];
          pending_matrices.delete(0);
          in_if.valid    <= 1'b1;
          in_if.entry_00 <= held_matrix.e00;
          in_if.entry_01 <= held_matrix.e01;
          in_if.entry_02 <= held_matrix.e02;
          in_if.entry_10 <= held_matrix.e10;
          in_if.entry_11 <= held_matrix.e11;
          in_if.entry_12 <= held_matrix.e12;
          in_if.entry_20 <= held_matrix.e20;
          in_if.entry_21 <= held_matrix.e21;
          in_if.entry_22 <= held_matrix.e22;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (angle_expected.size() == 0) begin
          report_mismatch("unexpected transfer", 16'd0, out_if.rotation_angle);
        end else begin
          angle_want = angle_expected[0];
          angle_expected.delete(0);
          if (out_if.rotation_angle !== angle_want)
            report_mismatch("rotation_angle", angle_want, out_if.rotation_angle);
        end
      end
      out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_rotation_angle_from_matrix_top: done, errors");
      $finish;
    end
  end

  initial begin
    int p;
    int k;
    clk = 1'b0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.entry_00 = '0;
    in_if.entry_01 = '0;
    in_if.entry_02 = '0;
    in_if.entry_10 = '0;
    in_if.entry_11 = '0;
    in_if.entry_12 = '0;
    in_if.entry_20 = '0;
    in_if.entry_21 = '0;
    in_if.entry_22 = '0;
    out_if.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    queue_entries(16384, 0, 0, 0, 16384, 0, 0, 0, 16384);
    queue_entries(0, 0, 0, 0, 0, 0, 0, 0, 0);
    queue_entries(16384, 0, 0, 0, -16384, 0, 0, 0, -16384);
    queue_entries(16384, 5, 7, 5, 0, -3, 7, -3, 0);
    queue_entries(16384, 0, 0, 0, 0, -16384, 0, 16384, 0);
    queue_entries(0, 0, 16384, 0, 16384, 0, -16384, 0, 0);
    queue_entries(0, -16384, 0, 16384, 0, 0, 0, 0, 16384);
    queue_entries(0, 16384, 0, -16384, 0, 0, 0, 0, 16384);
    queue_entries(-8192, -14189, 0, 14189, -8192, 0, 0, 0, 16384);
    queue_entries(8192, -14189, 0, 14189, 8192, 0, 0, 0, 16384);
    queue_entries(16384, -1, 0, 1, 16384, 0, 0, 0, 16384);
    queue_entries(16384, 0, 0, 0, -16384, -1, 0, 1, -16384);
    queue_entries(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    queue_entries(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    queue_entries(-32768, -32768, 32767, 32767, -32768, -32768, -32768, 32767, -32768);
    queue_entries(32767, -32768, 32767, 32767, 32767, -32768, -32768, 32767, 32767);
    queue_entries(-32768, 32767, -32768, -32768, -32768, 32767, 32767, -32768, -32768);
    queue_entries(21845, 21845, 21845, 21845, 21845, 21845, 21845, 21845, 21845);
    queue_entries(-21846, -21846, -21846, -21846, -21846, -21846, -21846, -21846, -21846);
    queue_entries(32767, 0, 0, 0, -32768, 0, 0, 0, 32767);
    queue_entries(-16384, 0, 0, 0, 16384, 0, 0, 0, 16384);
    queue_entries(0, 0, 0, 0, 0, 0, 0, 0, 16384);

    for (p = 0; p < 4; p++) begin
      @(negedge clk);
      idle_pct = idle_by_phase[p];
      stall_pct = stall_by_phase[p];
      for (k = 0; k < items_by_phase[p]; k++) queue_matrix(random_matrix());
      wait (items_taken == items_queued);
    end

    while (angle_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_rotation_angle_from_matrix_top: done, clean");
    end else begin
      $display("tb_rotation_angle_from_matrix_top: done, errors");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/rafm_pkg.sv
rtl/core/rafm_ifs.sv
rtl/core/rafm_front.sv
rtl/core/rafm_sqrt_cell.sv
rtl/core/rafm_cordic_cell.sv
rtl/core/rafm_back.sv
rtl/core/rotation_angle_from_matrix_top.sv
rtl/core/rafm_checker.sv
bench/tb_rotation_angle_from_matrix_top.sv
